FILE: hdl/bdlp_pkg.sv
// Package with payload types, register indexes and reset values for the button debouncer.
`timescale 1ns / 1ps

package bdlp_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;

  // Register and field widths.
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_MS_RST = 16'd2000;

  // Pin levels of the active-low button.
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  // Press kinds.
  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  // One raw sample with its timestamp.
  typedef struct packed {
    logic              raw_level;
    logic [TIME_W-1:0] now_ms;
    logic              ack_long;
  } in_t;

  // One qualified result.
  typedef struct packed {
    logic pressed;
    logic press_kind;
    logic long_latched;
    logic stable_level;
  } out_t;

endpackage

FILE: hdl/button_debounce_long_press_unit.sv
// Top level of the debouncer with short and long press detection.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid / in_stall | in_data (raw_level, now_ms, ack_long)
// out_     | output    | out_valid/out_stall | out_data (pressed, press_kind, long_latched,
//          |           |                     |           stable_level)
// cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One sample is taken per cycle while in_stall is low; its result is loaded into the output
// register at the transfer edge and can be taken by the sink from the next edge on.
// The whole state update is one pass of three 32-bit subtract-and-compare paths between
// the state registers and the output register, the long press check following the
// debounce check.
// Reset (synchronous, rst_n low) restores the released level, clears the timers and
// the long flag, and loads the default debounce and long press times.
// The input stalls only while a result sits in the output register and the sink stalls.
module button_debounce_long_press_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bdlp_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bdlp_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bdlp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bdlp_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] debounce_ms_r;
  logic [CFG_DATA_W-1:0] long_press_ms_r;

  // Debouncer state.
  logic              deb_level_r,   deb_level_nxt;
  logic              prev_sample_r;
  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic [TIME_W-1:0] last_change_r, last_change_nxt;
  logic              long_flag_r,   long_flag_nxt;

  // Output register.
  logic out_valid_r;
  out_t out_data_r, out_data_nxt;

  logic              in_xfer;
  logic              qualified;
  logic [TIME_W-1:0] held_rel;
  logic [TIME_W-1:0] held_now;
  logic              hit;
  logic              kind;

  // The input is free whenever the output register is empty or drains this cycle.
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One pass of the debounce and press detection for the accepted sample.
  always_comb begin
    long_flag_nxt   = in_data.ack_long ? 1'b0 : long_flag_r;
    last_change_nxt = (in_data.raw_level != prev_sample_r) ? in_data.now_ms : last_change_r;
    deb_level_nxt   = deb_level_r;
    press_start_nxt = press_start_r;
    hit             = 1'b0;
    kind            = KIND_SHORT;
    qualified       = (in_data.now_ms - last_change_nxt) >
                      {{(TIME_W-CFG_DATA_W){1'b0}}, debounce_ms_r};
    held_rel        = in_data.now_ms - press_start_r;

    if (qualified) begin
      if (in_data.raw_level != deb_level_r) begin
        deb_level_nxt = in_data.raw_level;
        if (in_data.raw_level == LEVEL_PRESSED) begin
          press_start_nxt = in_data.now_ms;
          long_flag_nxt   = 1'b0;
        end else begin
          if ((held_rel < {{(TIME_W-CFG_DATA_W){1'b0}}, long_press_ms_r}) &&
              !long_flag_nxt) begin
            hit  = 1'b1;
            kind = KIND_SHORT;
          end
          long_flag_nxt = 1'b0;
        end
      end
    end

    // A fresh press has held for zero time, otherwise the stored start is used.
    held_now = in_data.now_ms - press_start_nxt;
    if (qualified && (deb_level_nxt == LEVEL_PRESSED) && !long_flag_nxt &&
        (held_now >= {{(TIME_W-CFG_DATA_W){1'b0}}, long_press_ms_r})) begin
      long_flag_nxt = 1'b1;
      hit           = 1'b1;
      kind          = KIND_LONG;
    end

    out_data_nxt.pressed      = hit;
    out_data_nxt.press_kind   = hit ? kind : KIND_SHORT;
    out_data_nxt.long_latched = long_flag_nxt;
    out_data_nxt.stable_level = deb_level_nxt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r   <= DEBOUNCE_MS_RST;
      long_press_ms_r <= LONG_PRESS_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_ms_r   <= cfg_data;
        REG_LONG_PRESS: long_press_ms_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  // State update on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_level_r   <= LEVEL_RELEASED;
      prev_sample_r <= LEVEL_RELEASED;
      press_start_r <= '0;
      last_change_r <= '0;
      long_flag_r   <= 1'b0;
    end else if (in_xfer) begin
      deb_level_r   <= deb_level_nxt;
      prev_sample_r <= in_data.raw_level;
      press_start_r <= press_start_nxt;
      last_change_r <= last_change_nxt;
      long_flag_r   <= long_flag_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTH
  // A latched long flag only exists while the button is stably pressed.
  a_flag_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    long_flag_r |-> (deb_level_r == LEVEL_PRESSED))
    else $error("long flag set while released");

  // A long press report always leaves the flag latched.
  a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pressed && (out_data_r.press_kind == KIND_LONG))
      |-> out_data_r.long_latched)
    else $error("long press reported without latched flag");

  // A short press is reported only on a stable release.
  a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pressed && (out_data_r.press_kind == KIND_SHORT))
      |-> (out_data_r.stable_level == LEVEL_RELEASED))
    else $error("short press reported while pressed");

  // Every input transfer produces a result in the next cycle.
  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("input transfer without result");
`endif

endmodule

FILE: test/tb_button_debounce_long_press_unit.sv
// Self-checking testbench for the button debouncer with short and long press detection.
`timescale 1ns / 1ps

module tb_button_debounce_long_press_unit;
  import bdlp_pkg::*;

  localparam int DIRECTED_ITEMS    = 25;
  localparam int ITEMS_PER_SETTING = 100;
  localparam int SETTING_SLOTS     = 8;
  localparam int PHASE_ITEMS       = 275;
  localparam int PRINT_CAP         = 100;

  // Mirror of the debouncer: predicts one result per sample and checks them in order.
  class press_tracker;
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] long_ms;
    logic                  stable;
    logic                  prev_raw;
    logic                  long_flag;
    logic [TIME_W-1:0]     press_start;
    logic [TIME_W-1:0]     last_change;
    out_t                  pending_reports[$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           shorts;
    int unsigned           longs;

    function new();
      debounce_ms = DEBOUNCE_MS_RST;
      long_ms     = LONG_PRESS_MS_RST;
      stable      = LEVEL_RELEASED;
      prev_raw    = LEVEL_RELEASED;
      long_flag   = 1'b0;
      press_start = '0;
      last_change = '0;
      mismatches  = 0;
      checked     = 0;
      shorts      = 0;
      longs       = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DEBOUNCE:   debounce_ms = val;
        REG_LONG_PRESS: long_ms = val;
        default: ;
      endcase
    endfunction

    // Note an accepted sample and queue the result it must produce.
    function void take_sample(in_t s);
      logic              hit;
      logic              kind;
      logic [TIME_W-1:0] since;
      logic [TIME_W-1:0] held;
      out_t              r;
      hit  = 1'b0;
      kind = KIND_SHORT;
      // The acknowledge clears the latched flag before anything else.
      if (s.ack_long) long_flag = 1'b0;
      if (s.raw_level != prev_raw) last_change = s.now_ms;
      since = s.now_ms - last_change;
      if (since > debounce_ms) begin
        // A new stable level: a press starts timing, a release may report a short press.
        if (s.raw_level != stable) begin
          stable = s.raw_level;
          if (s.raw_level == LEVEL_PRESSED) begin
            press_start = s.now_ms;
            long_flag   = 1'b0;
          end else begin
            held = s.now_ms - press_start;
            if (held < long_ms && !long_flag) begin
              hit  = 1'b1;
              kind = KIND_SHORT;
            end
            long_flag = 1'b0;
          end
        end
        // Held long enough with the flag clear: latch and report a long press.
        if (stable == LEVEL_PRESSED && !long_flag) begin
          held = s.now_ms - press_start;
          if (held >= long_ms) begin
            long_flag = 1'b1;
            hit       = 1'b1;
            kind      = KIND_LONG;
          end
        end
      end
      prev_raw = s.raw_level;
      r.pressed      = hit;
      r.press_kind   = hit ? kind : KIND_SHORT;
      r.long_latched = long_flag;
      r.stable_level = stable;
      if (hit && kind == KIND_LONG) longs++;
      else if (hit) shorts++;
      pending_reports.push_back(r);
    endfunction

    task log_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task check_field(string name, logic got, logic want);
      if (got !== want)
        log_mismatch($sformatf("result %0d field %s is %b, expected %b", checked, name, got, want));
    endtask

    // Compare one transferred result with the oldest prediction.
    task match_report(out_t got);
      out_t want;
      checked++;
      if (pending_reports.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with no sample outstanding", checked));
        return;
      end
      want = pending_reports.pop_front();
      check_field("pressed", got.pressed, want.pressed);
      check_field("press_kind", got.press_kind, want.press_kind);
      check_field("long_latched", got.long_latched, want.long_latched);
      check_field("stable_level", got.stable_level, want.stable_level);
    endtask

    task close_out();
      if (pending_reports.size() != 0)
        log_mismatch($sformatf("%0d predicted results never arrived", pending_reports.size()));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  in_t                    in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_t                   out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  press_tracker      sb;
  logic [TIME_W-1:0] time_cursor = '0;
  int unsigned       items_sent = 0;
  int unsigned       src_idle_pct = 18;
  int unsigned       sink_idle_pct = 77;
  int unsigned       sink_hold_left = 0;

  button_debounce_long_press_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one sample at the given timestamp and hold it until the transfer.
  // Entered and left at a falling edge.
  task automatic offer_at(logic level, logic [TIME_W-1:0] t, logic ack);
    in_t s;
    s.raw_level = level;
    s.now_ms    = t;
    s.ack_long  = ack;
    time_cursor = t;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    sb.take_sample(s);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has been transferred.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write both timing registers back to back while the block is idle.
  task automatic apply_timing(logic [CFG_DATA_W-1:0] db, logic [CFG_DATA_W-1:0] lp);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= db;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_DEBOUNCE, db);
    @(negedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_data  <= lp;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_LONG_PRESS, lp);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One realistic press: bounce, hold short of or past the long time, bounce, release.
  task automatic press_episode();
    int unsigned gap;
    int unsigned lp;
    int unsigned hold;
    int unsigned elapsed;
    int unsigned step;
    gap = sb.debounce_ms + 32'd1;
    lp  = sb.long_ms;
    repeat ($urandom_range(0, 3))
      offer_at(1'($urandom_range(0, 1)), time_cursor + $urandom_range(0, gap), 1'b0);
    hold = $urandom_range(0, 1) ? $urandom_range(0, lp) : $urandom_range(lp, 2 * lp + gap);
    elapsed = 0;
    while (elapsed <= hold + gap) begin
      step = $urandom_range(1, gap + hold / 4 + 1);
      offer_at(LEVEL_PRESSED, time_cursor + step, $urandom_range(0, 9) == 0);
      elapsed += step;
    end
    repeat ($urandom_range(0, 3))
      offer_at(1'($urandom_range(0, 1)), time_cursor + $urandom_range(0, gap), 1'b0);
    repeat ($urandom_range(1, 3))
      offer_at(LEVEL_RELEASED, time_cursor + $urandom_range(gap / 2, gap + gap / 2),
               $urandom_range(0, 19) == 0);
  endtask

  // Fully random samples, timestamps jumping anywhere including backwards.
  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      offer_at(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_left > 0) begin
        out_stall <= 1'b1;
        sink_hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
      end
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.match_report(out_data);
  end

  initial begin
    logic [CFG_DATA_W-1:0] db_plan[SETTING_SLOTS];
    logic [CFG_DATA_W-1:0] lp_plan[SETTING_SLOTS];
    int                    slot;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed samples at the default timing of 50 ms and 2000 ms.
    offer_at(LEVEL_RELEASED, 32'd0, 1'b0);
    offer_at(LEVEL_PRESSED, 32'd100, 1'b0);
    offer_at(LEVEL_PRESSED, 32'd151, 1'b0);
    // Long press exactly at the limit, then an acknowledge that re-latches it.
    offer_at(LEVEL_PRESSED, 32'd2151, 1'b0);
    offer_at(LEVEL_PRESSED, 32'd2200, 1'b1);
    offer_at(LEVEL_RELEASED, 32'd2300, 1'b0);
    offer_at(LEVEL_RELEASED, 32'd2351, 1'b0);
    // Clean short press.
    offer_at(LEVEL_PRESSED, 32'd3000, 1'b0);
    offer_at(LEVEL_PRESSED, 32'd3051, 1'b0);
    offer_at(LEVEL_RELEASED, 32'd3100, 1'b0);
    offer_at(LEVEL_RELEASED, 32'd3151, 1'b0);
    // Contact bounce restarting the debounce timer.
    offer_at(LEVEL_PRESSED, 32'd4000, 1'b0);
    offer_at(LEVEL_RELEASED, 32'd4010, 1'b0);
    offer_at(LEVEL_PRESSED, 32'd4020, 1'b0);
    offer_at(LEVEL_PRESSED, 32'd4060, 1'b0);
    offer_at(LEVEL_PRESSED, 32'd4071, 1'b0);
    offer_at(LEVEL_RELEASED, 32'd4100, 1'b1);
    offer_at(LEVEL_RELEASED, 32'd4151, 1'b0);
    // Short press across the timestamp wrap.
    offer_at(LEVEL_PRESSED, 32'hFFFF_FFF0, 1'b0);
    offer_at(LEVEL_PRESSED, 32'h0000_0030, 1'b0);
    offer_at(LEVEL_RELEASED, 32'h0000_0050, 1'b0);
    offer_at(LEVEL_RELEASED, 32'h0000_0090, 1'b0);
    // Timestamp going backwards, then the all-ones timestamp.
    offer_at(LEVEL_PRESSED, 32'h0000_1000, 1'b0);
    offer_at(LEVEL_PRESSED, 32'h0000_0F00, 1'b0);
    offer_at(LEVEL_RELEASED, 32'hFFFF_FFFF, 1'b1);

    // Timing settings for the random part, the extremes among them.
    foreach (db_plan[i]) begin
      db_plan[i] = 16'($urandom_range(0, 40));
      lp_plan[i] = 16'($urandom_range(1, 300));
    end
    db_plan[0] = 16'd10;    lp_plan[0] = 16'd60;
    db_plan[1] = 16'd0;     lp_plan[1] = 16'd0;
    db_plan[3] = 16'hFFFF;  lp_plan[3] = 16'hFFFF;
    db_plan[4] = 16'd0;     lp_plan[4] = 16'd1;
    db_plan[6] = 16'hFFFF;  lp_plan[6] = 16'd1;

    time_cursor = $urandom;
    for (slot = 0; slot < SETTING_SLOTS; slot++) begin
      drain_results();
      apply_timing(db_plan[slot], lp_plan[slot]);
      // Hold the receiver off for a while so the output fills and stalls the input.
      if (slot == 2 || slot == 5) sink_hold_left = 80;
      while (items_sent < DIRECTED_ITEMS + (slot + 1) * ITEMS_PER_SETTING) begin
        if (items_sent < PHASE_ITEMS) begin
          src_idle_pct  = 18;
          sink_idle_pct = 77;
        end else if (items_sent < 2 * PHASE_ITEMS) begin
          src_idle_pct  = 77;
          sink_idle_pct = 18;
        end else begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < 12) noise_burst();
        else press_episode();
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    sb.close_out();
    $display("Covered %0d samples under %0d timing settings; %0d short and %0d long presses.",
             items_sent, SETTING_SLOTS + 1, sb.shorts, sb.longs);
    $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("button_debounce_long_press_unit test passed");
    end else begin
      $display("button_debounce_long_press_unit test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000;
    $display("button_debounce_long_press_unit test failed");
    $finish;
  end

endmodule
